// File: rtl/core/dbs_pkg.sv
package dbs_pkg;

  // Number of cells in the chain and the widths that follow from it.
  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int FUNC_W = 3;
  localparam int STAT_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_CONTAINS   = 3'd4,
    FN_REMOVE     = 3'd5
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What every cell does in the cycle of an accepted item.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHR,
    CELL_LOAD,
    CELL_SHL,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t                op;
    logic signed [VAL_W-1:0] item;
    logic [CNT_W-1:0]        count;
    logic [IDX_W-1:0]        last_idx;
    logic                    nonempty;
  } cell_ctrl_t;

  typedef struct packed {
    status_t          status;
    logic             found;
    logic [CNT_W-1:0] count;
  } result_t;

endpackage

// File: rtl/core/dbs_in_if.sv
interface dbs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [dbs_pkg::FUNC_W-1:0]           func;
  logic signed [dbs_pkg::VAL_W-1:0]     item_value;

  modport source (output valid, output func, output item_value, input ready);
  modport sink (input valid, input func, input item_value, output ready);
endinterface

// File: rtl/core/dbs_out_if.sv
interface dbs_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [dbs_pkg::STAT_W-1:0]           status;
  logic                                 found;
  logic signed [dbs_pkg::VAL_W-1:0]     front_value;
  logic signed [dbs_pkg::VAL_W-1:0]     back_value;
  logic [dbs_pkg::CNT_W-1:0]            entry_count;

  modport source (output valid, output status, output found, output front_value,
                  output back_value, output entry_count, input ready);
  modport sink (input valid, input status, input found, input front_value,
                input back_value, input entry_count, output ready);
endinterface

// File: rtl/core/dbs_cell.sv
module dbs_cell (
  input  logic                              clk,
  input  logic [dbs_pkg::IDX_W-1:0]         cell_idx,
  input  dbs_pkg::cell_ctrl_t               ctrl,
  input  logic signed [dbs_pkg::VAL_W-1:0]  left_val,
  input  logic signed [dbs_pkg::VAL_W-1:0]  right_val,
  input  logic                              hit_in,
  input  logic signed [dbs_pkg::VAL_W-1:0]  back_in,
  output logic signed [dbs_pkg::VAL_W-1:0]  value,
  output logic signed [dbs_pkg::VAL_W-1:0]  value_nxt,
  output logic                              hit_out,
  output logic signed [dbs_pkg::VAL_W-1:0]  back_out
);

  logic signed [dbs_pkg::VAL_W-1:0] value_r;
  logic [dbs_pkg::CNT_W-1:0]        idx_ext;
  logic                             occupied;
  logic                             match;
  logic                             back_sel;

  assign idx_ext  = {{(dbs_pkg::CNT_W - dbs_pkg::IDX_W){1'b0}}, cell_idx};
  assign occupied = idx_ext < ctrl.count;
  assign match    = occupied && (value_r == ctrl.item);
  assign hit_out  = hit_in | match;

  always_comb begin
    case (ctrl.op)
      dbs_pkg::CELL_SHR:    value_nxt = left_val;
      dbs_pkg::CELL_LOAD:   value_nxt = (idx_ext == ctrl.count) ? ctrl.item : value_r;
      dbs_pkg::CELL_SHL:    value_nxt = right_val;
      // Cells at or behind the first match take their right neighbor's value.
      dbs_pkg::CELL_REMOVE: value_nxt = hit_out ? right_val : value_r;
      default:              value_nxt = value_r;
    endcase
  end

  assign back_sel = ctrl.nonempty && (cell_idx == ctrl.last_idx);
  assign back_out = back_in | (back_sel ? value_nxt : '0);
  assign value    = value_r;

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

// File: rtl/core/dbs_ctrl.sv
module dbs_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  logic [dbs_pkg::FUNC_W-1:0]        func,
  input  logic signed [dbs_pkg::VAL_W-1:0]  item_value,
  input  logic                              hit_any,
  output dbs_pkg::cell_ctrl_t               ctrl,
  output dbs_pkg::result_t                  result
);

  localparam logic [dbs_pkg::CNT_W-1:0] FULL_CNT = dbs_pkg::CNT_W'(dbs_pkg::DEPTH);
  localparam logic [dbs_pkg::CNT_W-1:0] ONE_CNT  = dbs_pkg::CNT_W'(1);

  logic [dbs_pkg::CNT_W-1:0] count_r;
  logic [dbs_pkg::CNT_W-1:0] count_nxt;
  logic [dbs_pkg::CNT_W-1:0] last_cnt;
  logic                      empty;
  logic                      full;
  dbs_pkg::cell_op_t         op;
  dbs_pkg::status_t          status;
  logic                      found;

  assign empty = (count_r == '0);
  assign full  = (count_r == FULL_CNT);

  always_comb begin
    op        = dbs_pkg::CELL_HOLD;
    count_nxt = count_r;
    status    = dbs_pkg::ST_OK;
    found     = 1'b0;
    unique case (dbs_pkg::func_t'(func))
      dbs_pkg::FN_PUSH_FRONT, dbs_pkg::FN_PUSH_BACK: begin
        if (full) begin
          status = dbs_pkg::ST_FULL;
        end else begin
          op        = (func == dbs_pkg::FN_PUSH_FRONT) ? dbs_pkg::CELL_SHR
                                                       : dbs_pkg::CELL_LOAD;
          count_nxt = count_r + ONE_CNT;
        end
      end
      dbs_pkg::FN_POP_FRONT, dbs_pkg::FN_POP_BACK: begin
        if (empty) begin
          status = dbs_pkg::ST_EMPTY;
        end else begin
          op        = (func == dbs_pkg::FN_POP_FRONT) ? dbs_pkg::CELL_SHL
                                                      : dbs_pkg::CELL_HOLD;
          count_nxt = count_r - ONE_CNT;
        end
      end
      dbs_pkg::FN_CONTAINS: begin
        if (empty) begin
          status = dbs_pkg::ST_EMPTY;
        end else begin
          found = hit_any;
        end
      end
      dbs_pkg::FN_REMOVE: begin
        if (empty) begin
          status = dbs_pkg::ST_EMPTY;
        end else begin
          found = hit_any;
          op    = dbs_pkg::CELL_REMOVE;
          if (hit_any) begin
            count_nxt = count_r - ONE_CNT;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign last_cnt = count_nxt - ONE_CNT;

  always_comb begin
    ctrl.op       = accept ? op : dbs_pkg::CELL_HOLD;
    ctrl.item     = item_value;
    ctrl.count    = count_r;
    ctrl.last_idx = last_cnt[dbs_pkg::IDX_W-1:0];
    ctrl.nonempty = (count_nxt != '0);
  end

  always_comb begin
    result.status = status;
    result.found  = found;
    result.count  = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("fill count above depth");

  a_full_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && full && (func == dbs_pkg::FN_PUSH_FRONT || func == dbs_pkg::FN_PUSH_BACK))
    |=> $stable(count_r))
    else $error("push into a full store changed the count");

  a_miss_remove_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (func == dbs_pkg::FN_REMOVE) && !hit_any) |=> $stable(count_r))
    else $error("remove without a match changed the count");

endmodule

// File: rtl/core/deque_bag_store_top.sv
// Channel   Direction  Payload                                              Handshake
// in_ch     input      func, item_value                                     valid/ready
// out_ch    output     status, found, front_value, back_value, entry_count  valid/ready
//
// At the edge that accepts an item the cell chain updates and its result is loaded into
// the output register, which offers it from the next cycle on.
// One item can be accepted every cycle while the output is not stalled; the shifting cell
// chain updates at the edge that accepts the item.
// Reset (rst_n low at a clock edge) empties the store and the output register; cell
// contents are not cleared and are never read before they are written.
// A stalled output holds its result; a new item is taken only when the output register
// is empty or is being read in the same cycle.
module deque_bag_store_top (
  input  logic  clk,
  input  logic  rst_n,
  dbs_in_if.sink    in_ch,
  dbs_out_if.source out_ch
);

  localparam int DEPTH = dbs_pkg::DEPTH;

  // Neighbor links of the cell row. Cell 0 is the front of the deque.
  logic signed [dbs_pkg::VAL_W-1:0] cell_val  [DEPTH];
  logic signed [dbs_pkg::VAL_W-1:0] right_val [DEPTH];
  logic                             hit_link  [DEPTH+1];
  logic signed [dbs_pkg::VAL_W-1:0] back_link [DEPTH+1];
  logic signed [dbs_pkg::VAL_W-1:0] front_nxt;

  dbs_pkg::cell_ctrl_t ctrl;
  dbs_pkg::result_t    result;
  logic                accept;

  // Output register. Only its valid flag needs a reset.
  logic                              out_valid_r;
  logic [dbs_pkg::STAT_W-1:0]        status_r;
  logic                              found_r;
  logic signed [dbs_pkg::VAL_W-1:0]  front_r;
  logic signed [dbs_pkg::VAL_W-1:0]  back_r;
  logic [dbs_pkg::CNT_W-1:0]         count_r;

  // The output register decouples the two sides: a waiting result does not block the
  // next item as long as it is taken in the same cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  dbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .func       (in_ch.func),
    .item_value (in_ch.item_value),
    .hit_any    (hit_link[DEPTH]),
    .ctrl       (ctrl),
    .result     (result)
  );

  // The match flag ripples from the front, so each cell knows whether the first match
  // lies at or ahead of it. The back value is collected along the same row.
  assign hit_link[0]  = 1'b0;
  assign back_link[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_tail
      assign right_val[i] = cell_val[i];
    end else begin : g_mid
      assign right_val[i] = cell_val[i+1];
    end

    if (i == 0) begin : g_head
      // The head cell shifts in the pushed value on a front push.
      dbs_cell u_cell (
        .clk       (clk),
        .cell_idx  (dbs_pkg::IDX_W'(i)),
        .ctrl      (ctrl),
        .left_val  (in_ch.item_value),
        .right_val (right_val[i]),
        .hit_in    (hit_link[i]),
        .back_in   (back_link[i]),
        .value     (cell_val[i]),
        .value_nxt (front_nxt),
        .hit_out   (hit_link[i+1]),
        .back_out  (back_link[i+1])
      );
    end else begin : g_body
      dbs_cell u_cell (
        .clk       (clk),
        .cell_idx  (dbs_pkg::IDX_W'(i)),
        .ctrl      (ctrl),
        .left_val  (cell_val[i-1]),
        .right_val (right_val[i]),
        .hit_in    (hit_link[i]),
        .back_in   (back_link[i]),
        .value     (cell_val[i]),
        .value_nxt (),
        .hit_out   (hit_link[i+1]),
        .back_out  (back_link[i+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Front and back read zero when the store is empty after the operation; the back
  // collection already gives zero then since no cell is selected.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= result.status;
      found_r  <= result.found;
      front_r  <= (result.count != '0) ? front_nxt : '0;
      back_r   <= back_link[DEPTH];
      count_r  <= result.count;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.found       = found_r;
  assign out_ch.front_value = front_r;
  assign out_ch.back_value  = back_r;
  assign out_ch.entry_count = count_r;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted item produced no result");

  a_empty_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (count_r == '0)) |-> (front_r == '0) && (back_r == '0))
    else $error("empty store reported nonzero front or back");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> out_valid_r && $stable(status_r) &&
    $stable(found_r) && $stable(front_r) && $stable(back_r) && $stable(count_r))
    else $error("stalled result changed before it was read");

endmodule
